// ===== rtl/drd_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, queue item type and saturation helpers for the dead reckoning unit
// no dependencies

package drd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int ACC_W    = 17;
   localparam int VEL_W    = 40;
   localparam int POS_W    = 48;
   localparam int STEP_W   = 16;
   localparam int FRAC_W   = 16;
   localparam int AMAG_W   = 17;
   localparam int VMAG_W   = 41;

   localparam logic [STEP_W-1:0] STEP_RESET = 16'd6554;

   typedef struct packed {
      logic signed [ACC_W-1:0] acc_x;
      logic signed [ACC_W-1:0] acc_y;
      logic signed [ACC_W-1:0] acc_z;
      logic                    clear;
   } item_type;

   function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VEL_W+1:0] x);
      if (x[VEL_W+1:VEL_W-1] == 3'b000 || x[VEL_W+1:VEL_W-1] == 3'b111) begin
         return x[VEL_W-1:0];
      end else if (x[VEL_W+1]) begin
         return {1'b1, {(VEL_W-1){1'b0}}};
      end else begin
         return {1'b0, {(VEL_W-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] x);
      if (x[POS_W] == x[POS_W-1]) begin
         return x[POS_W-1:0];
      end else if (x[POS_W]) begin
         return {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         return {1'b0, {(POS_W-1){1'b1}}};
      end
   endfunction

endpackage

// ===== rtl/drd_queue.sv =====
`timescale 1ns / 1ps
// two-entry queue between the front and the back
// depends on drd_pkg

module drd_queue import drd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     not_empty
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/drd_front.sv =====
`timescale 1ns / 1ps
// input side: reference capture and relative acceleration per transaction
// depends on drd_pkg, feeds drd_queue

module drd_front import drd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_x,
   input  logic signed [SAMPLE_W-1:0] req_sample_y,
   input  logic signed [SAMPLE_W-1:0] req_sample_z,
   input  logic                       req_restart,
   output logic                       push,
   output item_type                   push_item,
   input  logic                       q_full
);

   logic signed [SAMPLE_W-1:0] ref_x_ff, ref_y_ff, ref_z_ff;
   logic                       ref_valid_ff;
   logic                       capture;

   assign req_ready = !q_full;
   assign push      = req_valid && req_ready;
   assign capture   = req_restart || !ref_valid_ff;

   always_comb begin
      push_item.clear = capture;
      if (capture) begin
         push_item.acc_x = '0;
         push_item.acc_y = '0;
         push_item.acc_z = '0;
      end else begin
         push_item.acc_x = {req_sample_x[SAMPLE_W-1], req_sample_x}
                         - {ref_x_ff[SAMPLE_W-1], ref_x_ff};
         push_item.acc_y = {req_sample_y[SAMPLE_W-1], req_sample_y}
                         - {ref_y_ff[SAMPLE_W-1], ref_y_ff};
         push_item.acc_z = {req_sample_z[SAMPLE_W-1], req_sample_z}
                         - {ref_z_ff[SAMPLE_W-1], ref_z_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_valid_ff <= 1'b0;
         ref_x_ff     <= '0;
         ref_y_ff     <= '0;
         ref_z_ff     <= '0;
      end else if (push && capture) begin
         ref_valid_ff <= 1'b1;
         ref_x_ff     <= req_sample_x;
         ref_y_ff     <= req_sample_y;
         ref_z_ff     <= req_sample_z;
      end
   end

endmodule

// ===== rtl/drd_isqrt.sv =====
`timescale 1ns / 1ps
// restoring integer square root, one root bit per cycle
// depends on nothing

module drd_isqrt #(
   parameter int ROOT_W = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2*ROOT_W-1:0]   radicand,
   output logic                  busy,
   output logic [ROOT_W-1:0]     root
);

   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [2*ROOT_W-1:0] rad_ff;
   logic [ROOT_W+1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [ROOT_W+3:0]   rem_sh, trial;

   assign busy = (cnt_ff != '0);
   assign root = root_ff;

   always_comb begin
      rem_sh = {rem_ff, rad_ff[2*ROOT_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      if (rem_sh >= trial) begin
         rem_in  = rem_sh[ROOT_W+1:0] - trial[ROOT_W+1:0];
         root_in = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh[ROOT_W+1:0];
         root_in = {root_ff[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(ROOT_W);
      end else if (busy) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy) begin
         rad_ff  <= {rad_ff[2*ROOT_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

endmodule

// ===== rtl/drd_back.sv =====
`timescale 1ns / 1ps
// execution side: integration, squared magnitudes, roots and result register
// depends on drd_pkg and drd_isqrt

module drd_back import drd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [STEP_W-1:0]        time_step,
   input  logic                     q_not_empty,
   input  item_type                 q_item,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [ACC_W-1:0]  rsp_acc_x,
   output logic signed [ACC_W-1:0]  rsp_acc_y,
   output logic signed [ACC_W-1:0]  rsp_acc_z,
   output logic [AMAG_W-1:0]        rsp_acc_mag,
   output logic signed [VEL_W-1:0]  rsp_vel_x,
   output logic signed [VEL_W-1:0]  rsp_vel_y,
   output logic signed [VEL_W-1:0]  rsp_vel_z,
   output logic [VMAG_W-1:0]        rsp_vel_mag,
   output logic signed [POS_W-1:0]  rsp_pos_x,
   output logic signed [POS_W-1:0]  rsp_pos_y,
   output logic signed [POS_W-1:0]  rsp_pos_z
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ISSUE = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_START = 3'd3;
   localparam logic [2:0] ST_ROOT  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [2:0] OP_DV   = 3'd0;
   localparam logic [2:0] OP_DP   = 3'd1;
   localparam logic [2:0] OP_SQA  = 3'd2;
   localparam logic [2:0] OP_SQV0 = 3'd3;
   localparam logic [2:0] OP_SQV1 = 3'd4;
   localparam logic [2:0] OP_SQV2 = 3'd5;

   localparam logic [1:0] AX_LAST = 2'd2;

   localparam int PROD_W = VEL_W + ACC_W + 1;
   localparam int DP_W   = PROD_W - FRAC_W;
   localparam int SQP_W  = VEL_W + STEP_W;
   localparam int ASQ_W  = 2 * AMAG_W;
   localparam int VSQ_W  = 2 * VMAG_W;

   logic [2:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic [1:0] ax_ff, ax_in;

   item_type                   cur_ff;
   logic signed [VEL_W-1:0]    vel_ff [3];
   logic signed [POS_W-1:0]    pos_ff [3];
   logic signed [PROD_W-1:0]   prod_ff;
   logic [ASQ_W-1:0]           acc_sq_ff;
   logic [VSQ_W-1:0]           vel_sq_ff;

   logic signed [ACC_W-1:0]    acc_sel;
   logic signed [VEL_W-1:0]    vel_sel;
   logic signed [POS_W-1:0]    pos_sel;
   logic [VEL_W-1:0]           vabs;
   logic [3*STEP_W-1:0]        vabs_ext;
   logic signed [VEL_W:0]      mul_a;
   logic signed [ACC_W-1:0]    mul_b;
   logic signed [VEL_W+1:0]    vsum;
   logic signed [PROD_W-1:0]   rnd;
   logic signed [DP_W-1:0]     dp;
   logic signed [POS_W:0]      psum;
   logic [VSQ_W-1:0]           sq_base, sq_add;

   logic                       sqrt_start, acc_busy, vel_busy, out_load;
   logic [AMAG_W-1:0]          acc_root;
   logic [VMAG_W-1:0]          vel_root;

   logic                       rsp_valid_ff;
   logic signed [ACC_W-1:0]    out_acc_ff [3];
   logic signed [VEL_W-1:0]    out_vel_ff [3];
   logic signed [POS_W-1:0]    out_pos_ff [3];
   logic [AMAG_W-1:0]          out_amag_ff;
   logic [VMAG_W-1:0]          out_vmag_ff;

   assign pop        = (state_ff == ST_IDLE) && q_not_empty;
   assign sqrt_start = (state_ff == ST_START);
   assign out_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      ax_in    = ax_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               state_in = ST_ISSUE;
               op_in    = OP_DV;
               ax_in    = 2'd0;
            end
         end
         ST_ISSUE: state_in = ST_ADD;
         ST_ADD: begin
            if (op_ff == OP_SQV2) begin
               op_in = OP_DV;
               if (ax_ff == AX_LAST) begin
                  state_in = ST_START;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = ST_ISSUE;
               end
            end else begin
               op_in    = op_ff + 3'd1;
               state_in = ST_ISSUE;
            end
         end
         ST_START: state_in = ST_ROOT;
         ST_ROOT: begin
            if (!acc_busy && !vel_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_DV;
         ax_ff    <= 2'd0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         ax_ff    <= ax_in;
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      unique case (ax_ff)
         2'd0:    acc_sel = cur_ff.acc_x;
         2'd1:    acc_sel = cur_ff.acc_y;
         default: acc_sel = cur_ff.acc_z;
      endcase
      vel_sel  = vel_ff[ax_ff];
      pos_sel  = pos_ff[ax_ff];
      vabs     = vel_sel[VEL_W-1] ? (~vel_sel + 1'b1) : vel_sel;
      vabs_ext = {{(3*STEP_W-VEL_W){1'b0}}, vabs};
      unique case (op_ff)
         OP_DV: begin
            mul_a = {{(VEL_W+1-ACC_W){acc_sel[ACC_W-1]}}, acc_sel};
            mul_b = {1'b0, time_step};
         end
         OP_DP: begin
            mul_a = {vel_sel[VEL_W-1], vel_sel};
            mul_b = {1'b0, time_step};
         end
         OP_SQA: begin
            mul_a = {{(VEL_W+1-ACC_W){acc_sel[ACC_W-1]}}, acc_sel};
            mul_b = acc_sel;
         end
         OP_SQV0: begin
            mul_a = {1'b0, vabs};
            mul_b = {1'b0, vabs_ext[STEP_W-1:0]};
         end
         OP_SQV1: begin
            mul_a = {1'b0, vabs};
            mul_b = {1'b0, vabs_ext[2*STEP_W-1:STEP_W]};
         end
         default: begin
            mul_a = {1'b0, vabs};
            mul_b = {1'b0, vabs_ext[3*STEP_W-1:2*STEP_W]};
         end
      endcase
   end

   // accumulate side of each step
   always_comb begin
      vsum    = {{2{vel_sel[VEL_W-1]}}, vel_sel} + prod_ff[VEL_W+1:0];
      rnd     = prod_ff + PROD_W'(1 << (FRAC_W - 1));
      dp      = rnd[PROD_W-1:FRAC_W];
      psum    = {pos_sel[POS_W-1], pos_sel} + {{(POS_W+1-DP_W){dp[DP_W-1]}}, dp};
      sq_base = {{(VSQ_W-SQP_W){1'b0}}, prod_ff[SQP_W-1:0]};
      unique case (op_ff)
         OP_SQV1: sq_add = sq_base << STEP_W;
         OP_SQV2: sq_add = sq_base << (2 * STEP_W);
         default: sq_add = sq_base;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff    <= q_item;
         acc_sq_ff <= '0;
         vel_sq_ff <= '0;
         if (q_item.clear) begin
            for (int i = 0; i < 3; i++) begin
               vel_ff[i] <= '0;
               pos_ff[i] <= '0;
            end
         end
      end
      if (state_ff == ST_ISSUE) begin
         prod_ff <= mul_a * mul_b;
      end
      if (state_ff == ST_ADD) begin
         unique case (op_ff)
            OP_DV:   vel_ff[ax_ff] <= sat_vel(vsum);
            OP_DP:   pos_ff[ax_ff] <= sat_pos(psum);
            OP_SQA:  acc_sq_ff     <= acc_sq_ff + prod_ff[ASQ_W-1:0];
            default: vel_sq_ff     <= vel_sq_ff + sq_add;
         endcase
      end
   end

   drd_isqrt #(.ROOT_W(AMAG_W)) u_acc_root (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc_sq_ff),
      .busy     (acc_busy),
      .root     (acc_root)
   );

   drd_isqrt #(.ROOT_W(VMAG_W)) u_vel_root (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (vel_sq_ff),
      .busy     (vel_busy),
      .root     (vel_root)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_acc_ff[0] <= cur_ff.acc_x;
         out_acc_ff[1] <= cur_ff.acc_y;
         out_acc_ff[2] <= cur_ff.acc_z;
         for (int i = 0; i < 3; i++) begin
            out_vel_ff[i] <= vel_ff[i];
            out_pos_ff[i] <= pos_ff[i];
         end
         out_amag_ff <= acc_root;
         out_vmag_ff <= vel_root;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_acc_x   = out_acc_ff[0];
   assign rsp_acc_y   = out_acc_ff[1];
   assign rsp_acc_z   = out_acc_ff[2];
   assign rsp_acc_mag = out_amag_ff;
   assign rsp_vel_x   = out_vel_ff[0];
   assign rsp_vel_y   = out_vel_ff[1];
   assign rsp_vel_z   = out_vel_ff[2];
   assign rsp_vel_mag = out_vmag_ff;
   assign rsp_pos_x   = out_pos_ff[0];
   assign rsp_pos_y   = out_pos_ff[1];
   assign rsp_pos_z   = out_pos_ff[2];

`ifndef SYNTHESIS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_not_empty)
      else $error("pop from empty queue");

   a_done_roots: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!acc_busy && !vel_busy))
      else $error("result taken while a root is still running");

   a_root_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START) |=> (acc_busy && vel_busy))
      else $error("root units did not start");

   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");
`endif

endmodule

// ===== rtl/accel_dead_reckoning_unit.sv =====
`timescale 1ns / 1ps
// accelerometer dead reckoning unit, top level
// depends on drd_pkg, drd_front, drd_queue, drd_back
//
// usage:
//   req_ channel carries one 3-axis sample per transaction; req_restart (or the
//   first transaction after reset) captures the sample as reference and clears
//   velocity and position, so that transaction returns all zeros
//   rsp_ channel returns one result per transaction: relative acceleration,
//   velocity and position per axis (16 fraction bits on velocity and position)
//   and floored root magnitudes of acceleration and velocity
//   csr_wr_en / csr_wr_data write the Q0.16 time step (reset 6554); write it
//   only while no transaction is in flight
// sequence:
//   the back end pops a transaction, runs a sequencer over one shared 41x17
//   multiplier, starts the two bit-serial root units and waits for them,
//   then loads the result register
//   the back end pops the next transaction only after that load; the front
//   keeps accepting into a two-entry queue while the back end is busy
// reset: synchronous, clears the reference, queue, sequencer and result valid
// stall: a result held in the result register does not block the next
//   computation; only the next result load waits for rsp_ready

module accel_dead_reckoning_unit import drd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [STEP_W-1:0]          csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_x,
   input  logic signed [SAMPLE_W-1:0] req_sample_y,
   input  logic signed [SAMPLE_W-1:0] req_sample_z,
   input  logic                       req_restart,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [ACC_W-1:0]    rsp_acc_x,
   output logic signed [ACC_W-1:0]    rsp_acc_y,
   output logic signed [ACC_W-1:0]    rsp_acc_z,
   output logic [AMAG_W-1:0]          rsp_acc_mag,
   output logic signed [VEL_W-1:0]    rsp_vel_x,
   output logic signed [VEL_W-1:0]    rsp_vel_y,
   output logic signed [VEL_W-1:0]    rsp_vel_z,
   output logic [VMAG_W-1:0]          rsp_vel_mag,
   output logic signed [POS_W-1:0]    rsp_pos_x,
   output logic signed [POS_W-1:0]    rsp_pos_y,
   output logic signed [POS_W-1:0]    rsp_pos_z
);

   logic [STEP_W-1:0] time_step_ff;
   logic              push, q_full, pop, q_not_empty;
   item_type          push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= STEP_RESET;
      end else if (csr_wr_en) begin
         time_step_ff <= csr_wr_data;
      end
   end

   drd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_sample_x (req_sample_x),
      .req_sample_y (req_sample_y),
      .req_sample_z (req_sample_z),
      .req_restart  (req_restart),
      .push         (push),
      .push_item    (push_item),
      .q_full       (q_full)
   );

   drd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .not_empty (q_not_empty)
   );

   drd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .time_step   (time_step_ff),
      .q_not_empty (q_not_empty),
      .q_item      (pop_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_acc_x   (rsp_acc_x),
      .rsp_acc_y   (rsp_acc_y),
      .rsp_acc_z   (rsp_acc_z),
      .rsp_acc_mag (rsp_acc_mag),
      .rsp_vel_x   (rsp_vel_x),
      .rsp_vel_y   (rsp_vel_y),
      .rsp_vel_z   (rsp_vel_z),
      .rsp_vel_mag (rsp_vel_mag),
      .rsp_pos_x   (rsp_pos_x),
      .rsp_pos_y   (rsp_pos_y),
      .rsp_pos_z   (rsp_pos_z)
   );

endmodule

// ===== bench/accel_dead_reckoning_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the accelerometer dead reckoning unit
// depends on drd_pkg and accel_dead_reckoning_unit; predicts each result in place

module accel_dead_reckoning_unit_test;
   import drd_pkg::*;

   localparam int QUIET_LIMIT = 20000;
   localparam int SETTLE      = 120;

   typedef struct {
      logic [ACC_W-1:0]  acc_x, acc_y, acc_z;
      logic [AMAG_W-1:0] acc_mag;
      logic [VEL_W-1:0]  vel_x, vel_y, vel_z;
      logic [VMAG_W-1:0] vel_mag;
      logic [POS_W-1:0]  pos_x, pos_y, pos_z;
   } motion_type;

   logic                       clock = 0;
   logic                       reset = 1;
   logic                       csr_wr_en = 0;
   logic [STEP_W-1:0]          csr_wr_data = '0;
   logic                       req_valid = 0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_x = '0, req_sample_y = '0, req_sample_z = '0;
   logic                       req_restart = 0;
   logic                       rsp_valid;
   logic                       rsp_ready = 0;
   logic signed [ACC_W-1:0]    rsp_acc_x, rsp_acc_y, rsp_acc_z;
   logic [AMAG_W-1:0]          rsp_acc_mag;
   logic signed [VEL_W-1:0]    rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic [VMAG_W-1:0]          rsp_vel_mag;
   logic signed [POS_W-1:0]    rsp_pos_x, rsp_pos_y, rsp_pos_z;

   accel_dead_reckoning_unit u_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_x(req_sample_x), .req_sample_y(req_sample_y),
      .req_sample_z(req_sample_z), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_acc_x(rsp_acc_x), .rsp_acc_y(rsp_acc_y), .rsp_acc_z(rsp_acc_z),
      .rsp_acc_mag(rsp_acc_mag),
      .rsp_vel_x(rsp_vel_x), .rsp_vel_y(rsp_vel_y), .rsp_vel_z(rsp_vel_z),
      .rsp_vel_mag(rsp_vel_mag),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z)
   );

   // predictor state
   longint  step_q = 6554;
   longint  ref_axis [3];
   bit      ref_held = 0;
   longint  vel_sum [3];
   longint  pos_sum [3];

   motion_type pending_motion [$];
   int      error_count = 0;
   int      idle_pct = 0;
   int      stall_pct = 0;
   int      hold_off = 0;
   bit      req_fire, rsp_fire;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_bits(longint x, int w);
      longint hi, lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   function automatic logic [83:0] floor_root3(longint a, longint b, longint c);
      logic [83:0] ua, ub, uc, total, root, cand;
      ua = 84'(a < 0 ? -a : a);
      ub = 84'(b < 0 ? -b : b);
      uc = 84'(c < 0 ? -c : c);
      total = ua * ua + ub * ub + uc * uc;
      root = '0;
      for (int bit_i = 41; bit_i >= 0; bit_i--) begin
         cand = root | (84'(1) << bit_i);
         if (cand * cand <= total) root = cand;
      end
      return root;
   endfunction

   function automatic motion_type integrate_sample(logic signed [15:0] sx, sy, sz, logic rst);
      motion_type  m;
      longint      s [3];
      longint      acc [3];
      longint      dp;
      logic [83:0] am, vm;
      s[0] = longint'(sx); s[1] = longint'(sy); s[2] = longint'(sz);
      if (rst || !ref_held) begin
         for (int i = 0; i < 3; i++) begin
            ref_axis[i] = s[i];
            vel_sum[i] = 0;
            pos_sum[i] = 0;
         end
         ref_held = 1;
      end
      for (int i = 0; i < 3; i++) begin
         acc[i] = s[i] - ref_axis[i];
         vel_sum[i] = clamp_bits(vel_sum[i] + acc[i] * step_q, VEL_W);
         dp = (vel_sum[i] * step_q + 32768) >>> 16;
         pos_sum[i] = clamp_bits(pos_sum[i] + dp, POS_W);
      end
      am = floor_root3(acc[0], acc[1], acc[2]);
      if (am > 84'(17'h1ffff)) am = 84'(17'h1ffff);
      vm = floor_root3(vel_sum[0], vel_sum[1], vel_sum[2]);
      if (vm > 84'(41'h1ffffffffff)) vm = 84'(41'h1ffffffffff);
      m.acc_x = acc[0][ACC_W-1:0];
      m.acc_y = acc[1][ACC_W-1:0];
      m.acc_z = acc[2][ACC_W-1:0];
      m.acc_mag = am[AMAG_W-1:0];
      m.vel_x = vel_sum[0][VEL_W-1:0];
      m.vel_y = vel_sum[1][VEL_W-1:0];
      m.vel_z = vel_sum[2][VEL_W-1:0];
      m.vel_mag = vm[VMAG_W-1:0];
      m.pos_x = pos_sum[0][POS_W-1:0];
      m.pos_y = pos_sum[1][POS_W-1:0];
      m.pos_z = pos_sum[2][POS_W-1:0];
      return m;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t %s: got %0h, expected %0h", $time, field, got, want);
      error_count++;
   endtask

   task automatic compare_field(string field, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch(field, got, want);
   endtask

   // result checker
   always @(posedge clock) begin
      motion_type m;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_motion.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(rsp_acc_x), 64'(0));
         end else begin
            m = pending_motion.pop_front();
            compare_field("acc_x", 64'(unsigned'(rsp_acc_x)), 64'(m.acc_x));
            compare_field("acc_y", 64'(unsigned'(rsp_acc_y)), 64'(m.acc_y));
            compare_field("acc_z", 64'(unsigned'(rsp_acc_z)), 64'(m.acc_z));
            compare_field("acc_mag", 64'(rsp_acc_mag), 64'(m.acc_mag));
            compare_field("vel_x", 64'(unsigned'(rsp_vel_x)), 64'(m.vel_x));
            compare_field("vel_y", 64'(unsigned'(rsp_vel_y)), 64'(m.vel_y));
            compare_field("vel_z", 64'(unsigned'(rsp_vel_z)), 64'(m.vel_z));
            compare_field("vel_mag", 64'(rsp_vel_mag), 64'(m.vel_mag));
            compare_field("pos_x", 64'(unsigned'(rsp_pos_x)), 64'(m.pos_x));
            compare_field("pos_y", 64'(unsigned'(rsp_pos_y)), 64'(m.pos_y));
            compare_field("pos_z", 64'(unsigned'(rsp_pos_z)), 64'(m.pos_z));
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles with no transaction
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         req_fire = req_valid && req_ready;
         rsp_fire = rsp_valid && rsp_ready;
         if (reset || req_fire || rsp_fire) quiet = 0;
         else quiet++;
      end
      $display("accel_dead_reckoning_unit: mismatch");
      $finish;
   end

   task automatic send_sample(logic signed [15:0] sx, sy, sz, logic rst);
      int gap;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_x <= sx;
      req_sample_y <= sy;
      req_sample_z <= sz;
      req_restart <= rst;
      do @(posedge clock); while (!req_ready);
      pending_motion.insert(pending_motion.size(), integrate_sample(sx, sy, sz, rst));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_motion.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_step(logic [STEP_W-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      csr_wr_data <= 16'($urandom);
      step_q = longint'(value);
   endtask

   task automatic test_reference_capture;
      send_sample(-16'sd32768, 16'sd32767, 16'sd0, 1'b0);
      send_sample(16'sd32767, -16'sd32768, -16'sd1, 1'b0);
      send_sample(16'sd32767, -16'sd32768, -16'sd1, 1'b0);
      send_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);
      send_sample(16'sd1234, -16'sd77, 16'sd32767, 1'b1);
      send_sample(-16'sd32768, 16'sd32767, -16'sd32768, 1'b0);
      send_sample(16'sd1234, -16'sd77, 16'sd32767, 1'b0);
   endtask

   task automatic test_step_extremes;
      write_step(16'd0);
      send_sample(16'sd100, 16'sd200, -16'sd300, 1'b0);
      send_sample(16'sd32767, -16'sd32768, 16'sd5, 1'b0);
      send_sample(16'sd0, 16'sd0, 16'sd0, 1'b1);
      send_sample(-16'sd32768, 16'sd32767, -16'sd32768, 1'b0);
      write_step(16'hffff);
      send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 1'b1);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
      send_sample(-16'sd32768, 16'sd0, 16'sd32767, 1'b0);
      write_step(16'd1);
      send_sample(16'sd32767, 16'sd1, -16'sd1, 1'b0);
      send_sample(-16'sd32768, 16'sd2, -16'sd2, 1'b0);
   endtask

   // drives velocity and then position into their limits, both signs
   task automatic test_saturation;
      write_step(16'hffff);
      send_sample(-16'sd32768, 16'sd32767, -16'sd32768, 1'b1);
      repeat (330) send_sample(16'sd32767, -16'sd32768, 16'sd32767, 1'b0);
      repeat (40) send_sample(-16'sd32768, 16'sd32767, -16'sd32768, 1'b0);
   endtask

   task automatic test_random_tracks(int count);
      int run;
      int sent;
      logic signed [15:0] bx, by, bz;
      sent = 0;
      while (sent < count) begin
         bx = 16'($urandom); by = 16'($urandom); bz = 16'($urandom);
         send_sample(bx, by, bz, 1'b1);
         sent++;
         run = $urandom_range(1, 25);
         repeat (run) begin
            if ($urandom_range(9) == 0)
               send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                           1'($urandom_range(1)));
            else
               send_sample(bx + $signed(16'($urandom_range(0, 4000)) - 16'sd2000),
                           by + $signed(16'($urandom_range(0, 4000)) - 16'sd2000),
                           bz + $signed(16'($urandom_range(0, 4000)) - 16'sd2000), 1'b0);
            sent++;
         end
      end
   endtask

   task automatic test_backpressure;
      hold_off = 1500;
      repeat (12) send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                              1'($urandom_range(1)));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reference_capture();
      test_step_extremes();
      write_step(16'd6554);
      test_random_tracks(120);
      test_saturation();
      idle_pct = 85;
      write_step(16'($urandom));
      test_random_tracks(120);
      idle_pct = 0;
      stall_pct = 85;
      write_step(16'($urandom_range(1, 65535)));
      test_random_tracks(120);
      idle_pct = 35;
      stall_pct = 35;
      write_step(16'($urandom));
      test_random_tracks(120);
      test_backpressure();
      drain();
      if (error_count == 0)
         $display("accel_dead_reckoning_unit: match");
      else
         $display("accel_dead_reckoning_unit: mismatch");
      $finish;
   end

endmodule
